### rtl/kbf_pkg.sv
// shared types, constants and the step program of the angle/bias kalman filter
// used by every module of the block, no dependencies
package kbf_pkg;

  // value format: signed Q24.24 in 48 bits
  localparam int W         = 48;
  localparam int F         = 24;
  localparam int H         = W / 2;
  localparam int CFG_W     = 32;
  localparam int IN_W      = 16;
  localparam int MAG_W     = W + F;
  localparam int DIV_STEPS = W + F;
  localparam int MUL_STEPS = 4;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W    = 4;
  localparam int PC_W      = 5;
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(29);

  // register reset values, unsigned Q8.24
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = CFG_W'(5033165);
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = CFG_W'(503316);
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = CFG_W'(1342177);
  localparam logic [CFG_W-1:0] TIME_STEP_RST     = CFG_W'(167772);

  typedef enum logic [1:0] {
    REG_ANGLE_NOISE   = 2'd0,
    REG_BIAS_NOISE    = 2'd1,
    REG_MEASURE_NOISE = 2'd2,
    REG_TIME_STEP     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // operand and destination selects
  typedef enum logic [4:0] {
    SEL_ANGLE = 5'd0,
    SEL_BIAS  = 5'd1,
    SEL_CAA   = 5'd2,
    SEL_CAB   = 5'd3,
    SEL_CBA   = 5'd4,
    SEL_CBB   = 5'd5,
    SEL_T     = 5'd6,
    SEL_DP    = 5'd7,
    SEL_S     = 5'd8,
    SEL_K0    = 5'd9,
    SEL_K1    = 5'd10,
    SEL_Y     = 5'd11,
    SEL_ACC   = 5'd12,
    SEL_GYRO  = 5'd13,
    SEL_DT    = 5'd14,
    SEL_QA    = 5'd15,
    SEL_QB    = 5'd16,
    SEL_RM    = 5'd17
  } sel_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  typedef struct packed {
    op_e  op;
    sel_e a;
    sel_e b;
    sel_e dst;
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t uop;
    logic load_in;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  // one filter step as a list of operations
  function automatic uop_t kbf_prog(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_ADD, SEL_T, SEL_T, SEL_T};
    case (pc)
      // angle prediction
      5'd0:  u = '{OP_SUB, SEL_GYRO, SEL_BIAS, SEL_T};
      5'd1:  u = '{OP_MUL, SEL_DT, SEL_T, SEL_T};
      5'd2:  u = '{OP_ADD, SEL_ANGLE, SEL_T, SEL_ANGLE};
      // covariance prediction
      5'd3:  u = '{OP_MUL, SEL_DT, SEL_CBB, SEL_T};
      5'd4:  u = '{OP_SUB, SEL_T, SEL_CAB, SEL_T};
      5'd5:  u = '{OP_SUB, SEL_T, SEL_CBA, SEL_T};
      5'd6:  u = '{OP_ADD, SEL_T, SEL_QA, SEL_T};
      5'd7:  u = '{OP_MUL, SEL_DT, SEL_T, SEL_T};
      5'd8:  u = '{OP_ADD, SEL_CAA, SEL_T, SEL_CAA};
      5'd9:  u = '{OP_MUL, SEL_DT, SEL_CBB, SEL_DP};
      5'd10: u = '{OP_SUB, SEL_CAB, SEL_DP, SEL_CAB};
      5'd11: u = '{OP_SUB, SEL_CBA, SEL_DP, SEL_CBA};
      5'd12: u = '{OP_MUL, SEL_QB, SEL_DT, SEL_T};
      5'd13: u = '{OP_ADD, SEL_CBB, SEL_T, SEL_CBB};
      // gains
      5'd14: u = '{OP_ADD, SEL_CAA, SEL_RM, SEL_S};
      5'd15: u = '{OP_DIV, SEL_CAA, SEL_S, SEL_K0};
      5'd16: u = '{OP_DIV, SEL_CBA, SEL_S, SEL_K1};
      // state correction
      5'd17: u = '{OP_SUB, SEL_ACC, SEL_ANGLE, SEL_Y};
      5'd18: u = '{OP_MUL, SEL_K0, SEL_Y, SEL_T};
      5'd19: u = '{OP_ADD, SEL_ANGLE, SEL_T, SEL_ANGLE};
      5'd20: u = '{OP_MUL, SEL_K1, SEL_Y, SEL_T};
      5'd21: u = '{OP_ADD, SEL_BIAS, SEL_T, SEL_BIAS};
      // covariance update, products from the old values first
      5'd22: u = '{OP_MUL, SEL_K0, SEL_CAA, SEL_T};
      5'd23: u = '{OP_MUL, SEL_K0, SEL_CAB, SEL_DP};
      5'd24: u = '{OP_MUL, SEL_K1, SEL_CAA, SEL_Y};
      5'd25: u = '{OP_MUL, SEL_K1, SEL_CAB, SEL_S};
      5'd26: u = '{OP_SUB, SEL_CAA, SEL_T, SEL_CAA};
      5'd27: u = '{OP_SUB, SEL_CAB, SEL_DP, SEL_CAB};
      5'd28: u = '{OP_SUB, SEL_CBA, SEL_Y, SEL_CBA};
      5'd29: u = '{OP_SUB, SEL_CBB, SEL_S, SEL_CBB};
      default: u = '{OP_ADD, SEL_T, SEL_T, SEL_T};
    endcase
    return u;
  endfunction

endpackage

### rtl/kbf_in_if.sv
// input channel: one accelerometer angle and one gyro rate per word
// depends on kbf_pkg
interface kbf_in_if;
  import kbf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] accel_measure;
  logic signed [IN_W-1:0] gyro_rate;
  modport source (output valid, output accel_measure, output gyro_rate, input ready);
  modport sink (input valid, input accel_measure, input gyro_rate, output ready);
endinterface

// output channel: one angle estimate per word
interface kbf_out_if;
  import kbf_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] angle_estimate;
  modport source (output valid, output angle_estimate, input ready);
  modport sink (input valid, input angle_estimate, output ready);
endinterface

### rtl/angle_bias_kalman_filter.sv
// top level of the two-state angle/bias kalman filter
// depends on kbf_pkg, kbf_in_if, kbf_out_if, kbf_ctrl, kbf_dpath
//
// usage: each word on in_i carries an accelerometer angle and a gyro rate in
// raw counts; for each accepted word exactly one word leaves on out_o with the
// new angle estimate, signed Q24.24 in 48 bits, saturated.
// in_i.ready is high only while the block is idle; out_o.valid rises once the
// step is done and its result loaded, and the next word is taken once the block
// is idle again: 30 operations issued one at a time, add and subtract on a
// saturating adder, a multiply (four 24x24 partial products) and a divide (one
// quotient bit per cycle, 72 bits) on one shared unit, two divides per word.
// the result sits in an output register, so the next word is accepted while
// it waits; if the receiver still stalls at the end of that next word, the
// block holds it until the output register is free.
// reset clears angle, bias and covariance and loads the default noise and
// time step registers; there is no clearing pass.
// registers on the apb port: 0x0 angle noise, 0x4 bias noise, 0x8 measurement
// noise, 0xc time step, all unsigned Q8.24; write only while idle.
module angle_bias_kalman_filter import kbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  kbf_in_if.sink            in_i,
  kbf_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  logic [CFG_W-1:0] angle_noise_q, bias_noise_q, measure_noise_q, time_step_q;
  reg_idx_e         ridx;
  cmd_t             cmd;
  stat_t            stat;

  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_noise_q   <= ANGLE_NOISE_RST;
      bias_noise_q    <= BIAS_NOISE_RST;
      measure_noise_q <= MEASURE_NOISE_RST;
      time_step_q     <= TIME_STEP_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ANGLE_NOISE:   angle_noise_q   <= pwdata;
        REG_BIAS_NOISE:    bias_noise_q    <= pwdata;
        REG_MEASURE_NOISE: measure_noise_q <= pwdata;
        REG_TIME_STEP:     time_step_q     <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (ridx)
      REG_ANGLE_NOISE:   prdata = angle_noise_q;
      REG_BIAS_NOISE:    prdata = bias_noise_q;
      REG_MEASURE_NOISE: prdata = measure_noise_q;
      REG_TIME_STEP:     prdata = time_step_q;
      default:           prdata = '0;
    endcase
  end

  kbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kbf_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .accel_i         (in_i.accel_measure),
    .gyro_i          (in_i.gyro_rate),
    .angle_noise_i   (angle_noise_q),
    .bias_noise_i    (bias_noise_q),
    .measure_noise_i (measure_noise_q),
    .time_step_i     (time_step_q),
    .angle_o         (out_o.angle_estimate)
  );

endmodule

### rtl/kbf_ctrl.sv
// controller: steps the operation program and runs both handshakes
// depends on kbf_pkg
module kbf_ctrl import kbf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;

  // state, program counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.uop     = kbf_prog(pc_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          pc_d          = '0;
          state_d       = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.done) begin
          if (pc_q == PC_LAST) begin
            state_d = ST_EMIT;
          end else begin
            pc_d    = pc_q + PC_W'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/kbf_dpath.sv
// datapath: filter state, saturating add/sub, partial-product multiplier, bit-serial divider
// depends on kbf_pkg
module kbf_dpath import kbf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic signed [IN_W-1:0] accel_i,
  input  logic signed [IN_W-1:0] gyro_i,
  input  logic [CFG_W-1:0]       angle_noise_i,
  input  logic [CFG_W-1:0]       bias_noise_i,
  input  logic [CFG_W-1:0]       measure_noise_i,
  input  logic [CFG_W-1:0]       time_step_i,
  output logic signed [W-1:0]    angle_o
);

  logic signed [W-1:0] angle_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
  logic signed [W-1:0] t_q, dp_q, s_q, k0_q, k1_q, y_q;
  logic signed [IN_W-1:0] acc_q, gyro_q;
  logic signed [W-1:0] out_q;

  logic               busy_q, done_q, neg_q;
  op_e                op_q;
  sel_e               dst_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [W-1:0]       xm_q, ym_q;
  logic [2*W-1:0]     acc_prod_q;
  logic [MAG_W-1:0]   dvd_q, quo_q;
  logic [W-1:0]       rem_q;

  logic signed [W-1:0] va, vb, as_res, fin_res, wr_val;
  logic [W:0]          as_sum, rem_sh;
  logic [W-1:0]        ma, mb, lim, mg;
  logic [H-1:0]        xs, ys;
  logic [2*H-1:0]      pp;
  logic [2*W-1:0]      pp_sh;
  logic [MAG_W-1:0]    mag_f;
  logic                wr_en, fin;

  // operand select
  function automatic logic signed [W-1:0] pick(input sel_e s,
      input logic signed [W-1:0] angle, bias, caa, cab, cba, cbb, t, dp, sv, k0, k1, y,
      input logic signed [IN_W-1:0] accv, gyrov, input logic [CFG_W-1:0] dt, qa, qb, rm);
    logic signed [W-1:0] v;
    case (s)
      SEL_ANGLE: v = angle;
      SEL_BIAS:  v = bias;
      SEL_CAA:   v = caa;
      SEL_CAB:   v = cab;
      SEL_CBA:   v = cba;
      SEL_CBB:   v = cbb;
      SEL_T:     v = t;
      SEL_DP:    v = dp;
      SEL_S:     v = sv;
      SEL_K0:    v = k0;
      SEL_K1:    v = k1;
      SEL_Y:     v = y;
      SEL_ACC:   v = {{(W-IN_W-F){accv[IN_W-1]}}, accv, {F{1'b0}}};
      SEL_GYRO:  v = {{(W-IN_W-F){gyrov[IN_W-1]}}, gyrov, {F{1'b0}}};
      SEL_DT:    v = {{(W-CFG_W){1'b0}}, dt};
      SEL_QA:    v = {{(W-CFG_W){1'b0}}, qa};
      SEL_QB:    v = {{(W-CFG_W){1'b0}}, qb};
      SEL_RM:    v = {{(W-CFG_W){1'b0}}, rm};
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    va = pick(cmd_i.uop.a, angle_q, bias_q, caa_q, cab_q, cba_q, cbb_q, t_q, dp_q, s_q,
              k0_q, k1_q, y_q, acc_q, gyro_q, time_step_i, angle_noise_i, bias_noise_i,
              measure_noise_i);
    vb = pick(cmd_i.uop.b, angle_q, bias_q, caa_q, cab_q, cba_q, cbb_q, t_q, dp_q, s_q,
              k0_q, k1_q, y_q, acc_q, gyro_q, time_step_i, angle_noise_i, bias_noise_i,
              measure_noise_i);
    ma = va[W-1] ? W'(-va) : W'(va);
    mb = vb[W-1] ? W'(-vb) : W'(vb);
  end

  // saturating add or subtract
  always_comb begin
    if (cmd_i.uop.op == OP_SUB) as_sum = {va[W-1], va} - {vb[W-1], vb};
    else                        as_sum = {va[W-1], va} + {vb[W-1], vb};
    if (as_sum[W] != as_sum[W-1])
      as_res = as_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else
      as_res = as_sum[W-1:0];
  end

  // one partial product per cycle
  always_comb begin
    xs    = cnt_q[1] ? xm_q[W-1:H] : xm_q[H-1:0];
    ys    = cnt_q[0] ? ym_q[W-1:H] : ym_q[H-1:0];
    pp    = xs * ys;
    pp_sh = (2*W)'(pp) << ((cnt_q[1] ? H : 0) + (cnt_q[0] ? H : 0));
  end

  // one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[MAG_W-1]};

  // finish: truncated magnitude, clamp, sign
  always_comb begin
    if (op_q == OP_MUL)  mag_f = acc_prod_q[2*W-1:F];
    else if (ym_q == '0) mag_f = '0;
    else                 mag_f = quo_q;
    lim     = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mg      = (mag_f > MAG_W'(lim)) ? lim : mag_f[W-1:0];
    fin_res = neg_q ? W'(-mg) : W'(mg);
    fin     = busy_q && ((op_q == OP_MUL) ? (cnt_q == CNT_W'(MUL_STEPS))
                                          : (cnt_q == CNT_W'(DIV_STEPS)));
  end

  // result write port
  always_comb begin
    wr_en  = 1'b0;
    wr_val = as_res;
    if (cmd_i.start && (cmd_i.uop.op == OP_ADD || cmd_i.uop.op == OP_SUB)) begin
      wr_en = 1'b1;
    end else if (fin) begin
      wr_en  = 1'b1;
      wr_val = fin_res;
    end
  end

  // filter state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      caa_q   <= '0;
      cab_q   <= '0;
      cba_q   <= '0;
      cbb_q   <= '0;
    end else if (wr_en) begin
      case (fin ? dst_q : cmd_i.uop.dst)
        SEL_ANGLE: angle_q <= wr_val;
        SEL_BIAS:  bias_q  <= wr_val;
        SEL_CAA:   caa_q   <= wr_val;
        SEL_CAB:   cab_q   <= wr_val;
        SEL_CBA:   cba_q   <= wr_val;
        SEL_CBB:   cbb_q   <= wr_val;
        default: ;
      endcase
    end
  end

  // scratch values, input and output registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (fin ? dst_q : cmd_i.uop.dst)
        SEL_T:   t_q  <= wr_val;
        SEL_DP:  dp_q <= wr_val;
        SEL_S:   s_q  <= wr_val;
        SEL_K0:  k0_q <= wr_val;
        SEL_K1:  k1_q <= wr_val;
        SEL_Y:   y_q  <= wr_val;
        default: ;
      endcase
    end
    if (cmd_i.load_in) begin
      acc_q  <= accel_i;
      gyro_q <= gyro_i;
    end
    if (cmd_i.load_out) out_q <= angle_q;
  end

  // multi-cycle unit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        cnt_q <= '0;
        if (cmd_i.uop.op == OP_ADD || cmd_i.uop.op == OP_SUB) done_q <= 1'b1;
        else                                                  busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // multiplier and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q       <= cmd_i.uop.op;
      dst_q      <= cmd_i.uop.dst;
      neg_q      <= va[W-1] ^ vb[W-1];
      xm_q       <= ma;
      ym_q       <= mb;
      acc_prod_q <= '0;
      dvd_q      <= {ma, {F{1'b0}}};
      quo_q      <= '0;
      rem_q      <= '0;
    end else if (busy_q && !fin) begin
      if (op_q == OP_MUL) begin
        acc_prod_q <= acc_prod_q + pp_sh;
      end else begin
        dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, ym_q}) begin
          rem_q <= W'(rem_sh - {1'b0, ym_q});
          quo_q <= {quo_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[W-1:0];
          quo_q <= {quo_q[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign angle_o     = out_q;

endmodule
